FILE: sv/sha_pkg.sv
`default_nettype none

package sha_pkg;

  typedef logic [0:7][31:0] word8_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_COMP = 4'b0010,
    ST_PAD  = 4'b0100,
    ST_DONE = 4'b1000
  } top_state_t;

  typedef enum logic [3:0] {
    PAD_NONE = 4'b0001,
    PAD_MARK = 4'b0010,
    PAD_ZERO = 4'b0100,
    PAD_LEN  = 4'b1000
  } pad_stage_t;

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_PREP = 4'b0010,
    C_RUN  = 4'b0100,
    C_FIN  = 4'b1000
  } core_state_t;

  typedef struct packed {
    logic       push;
    logic       word_done;
    logic [7:0] data;
    logic       step;
    logic       calc;
  } sched_ctl_t;

  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] RND_LAST  = 6'd63;
  localparam logic [5:0] RND_CALC  = 6'd15;
  localparam logic [7:0] PAD_BYTE  = 8'h80;

  localparam word8_t IV = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

FILE: sv/sha_if.sv
`default_nettype none

interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_valid, output end_of_message,
                  input ready);
  modport sink (input valid, input data_byte, input byte_valid, input end_of_message,
                output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

`default_nettype wire

FILE: sv/sha_sched.sv
`default_nettype none

module sha_sched
  import sha_pkg::*;
(
  input  wire logic        clk,
  input  wire sched_ctl_t  ctl,
  output logic [31:0]      w
);

  logic [31:0] win_r [16];
  logic [23:0] acc_r;
  logic [31:0] w_r;
  logic [31:0] new_w;

  always_comb begin
    if (ctl.calc) begin
      new_w = small_sig1(win_r[14]) + win_r[9] + small_sig0(win_r[1]) + win_r[0];
    end else begin
      new_w = win_r[0];
    end
  end

  always_ff @(posedge clk) begin
    priority if (ctl.push) begin
      if (ctl.word_done) begin
        for (int i = 0; i < 15; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[15] <= {acc_r, ctl.data};
      end else begin
        acc_r <= {acc_r[15:0], ctl.data};
      end
    end else if (ctl.step) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= new_w;
      w_r       <= new_w;
    end
  end

  assign w = w_r;

endmodule

`default_nettype wire

FILE: sv/sha_core.sv
`default_nettype none

module sha_core
  import sha_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   start,
  input  wire logic   clear,
  input  wire logic [31:0] w,
  output logic        busy,
  output logic        done,
  output logic        step,
  output logic        calc,
  output word8_t      chain
);

  core_state_t state_r, state_nxt;
  logic [5:0]  rnd_r;
  word8_t      chain_r;
  word8_t      wv_r;
  logic [31:0] t1, t2, ch, maj;

  always_comb begin
    ch  = (wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]);
    maj = (wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2]) ^ (wv_r[1] & wv_r[2]);
    t1  = wv_r[7] + big_sig1(wv_r[4]) + ch + K_TAB[rnd_r] + w;
    t2  = big_sig0(wv_r[0]) + maj;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE: if (start) state_nxt = C_PREP;
      C_PREP: state_nxt = C_RUN;
      C_RUN:  if (rnd_r == RND_LAST) state_nxt = C_FIN;
      C_FIN:  state_nxt = C_IDLE;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      rnd_r   <= '0;
      chain_r <= IV;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        C_IDLE: if (clear) chain_r <= IV;
        C_PREP: rnd_r <= '0;
        C_RUN:  rnd_r <= rnd_r + 6'd1;
        C_FIN: begin
          for (int i = 0; i < 8; i++) begin
            chain_r[i] <= chain_r[i] + wv_r[i];
          end
        end
        default: rnd_r <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == C_IDLE && start) begin
      wv_r <= chain_r;
    end else if (state_r == C_RUN) begin
      wv_r[7] <= wv_r[6];
      wv_r[6] <= wv_r[5];
      wv_r[5] <= wv_r[4];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[3] <= wv_r[2];
      wv_r[2] <= wv_r[1];
      wv_r[1] <= wv_r[0];
      wv_r[0] <= t1 + t2;
    end
  end

  assign busy  = (state_r != C_IDLE);
  assign done  = (state_r == C_FIN);
  assign step  = (state_r == C_PREP) || (state_r == C_RUN);
  assign calc  = (state_r == C_RUN) && (rnd_r >= RND_CALC);
  assign chain = chain_r;

  a_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##66 done)
    else $error("compression did not finish on time");

  a_no_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    clear |-> !busy && !start)
    else $error("chain cleared during compression");

endmodule

`default_nettype wire

FILE: sv/sha_out.sv
`default_nettype none

module sha_out
  import sha_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire word8_t  digest,
  output logic         busy,
  sha_out_if.source    out_ch
);

  word8_t     words_r;
  logic [3:0] cnt_r;
  logic [2:0] idx_r;
  logic       take;

  assign take = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      cnt_r <= 4'd8;
      idx_r <= '0;
    end else if (take) begin
      cnt_r <= cnt_r - 4'd1;
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      words_r <= digest;
    end else if (take) begin
      for (int i = 0; i < 7; i++) begin
        words_r[i] <= words_r[i+1];
      end
    end
  end

  assign busy               = (cnt_r != 4'd0);
  assign out_ch.valid       = busy;
  assign out_ch.digest_word = words_r[0];
  assign out_ch.word_index  = idx_r;
  assign out_ch.last_word   = (cnt_r == 4'd1);

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !busy)
    else $error("digest loaded over pending words");

  a_load_first: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_ch.valid && out_ch.word_index == 3'd0)
    else $error("digest load did not present word zero");

endmodule

`default_nettype wire

FILE: sv/sha256_message_hasher.sv
`default_nettype none

// Channel   Direction  Payload                                      Handshake
// in_ch     sink       data_byte[8], byte_valid, end_of_message     valid/ready
// out_ch    source     digest_word[32], word_index[3], last_word    valid/ready
//
// A byte transaction that completes a 64-byte block starts a compression
// (1 schedule prime, 64 rounds on the shared round unit, 1 chain update).
// An end-of-message transaction then pads one byte per cycle outside compression (up to
// 72 bytes), compressing each filled block, then loads the digest.
// Eight digest words drain from an output register while the next message streams in.
// rst_n is synchronous and clears control and the chain value; no clearing pass.
// A stalled out_ch holds the next end-of-message in the load step until the digest drains.

module sha256_message_hasher
  import sha_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  sha_in_if.sink     in_ch,
  sha_out_if.source  out_ch
);

  top_state_t  state_r, state_nxt;
  pad_stage_t  pad_r, pad_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;

  logic        in_acc;
  logic        push;
  logic [7:0]  push_byte;
  logic [7:0]  len_byte;
  logic        core_start, core_clear, core_busy, core_done, core_step, core_calc;
  logic        out_load, out_busy;
  logic [31:0] sched_w;
  word8_t      chain;
  sched_ctl_t  sched_ctl;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign len_byte    = 8'(bits_r >> {~fill_r[2:0], 3'b000});

  always_comb begin
    state_nxt  = state_r;
    pad_nxt    = pad_r;
    bits_nxt   = bits_r;
    push       = 1'b0;
    push_byte  = 8'h00;
    out_load   = 1'b0;
    core_clear = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.byte_valid) begin
            push      = 1'b1;
            push_byte = in_ch.data_byte;
            bits_nxt  = bits_r + 64'd8;
          end
          if (in_ch.end_of_message) pad_nxt = PAD_MARK;
          if (in_ch.byte_valid && fill_r == FILL_LAST) begin
            state_nxt = ST_COMP;
          end else if (in_ch.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push = 1'b1;
        unique case (pad_r)
          PAD_MARK: begin
            push_byte = PAD_BYTE;
            pad_nxt   = PAD_ZERO;
          end
          PAD_ZERO: begin
            if (fill_r == LEN_START) begin
              push_byte = len_byte;
              pad_nxt   = PAD_LEN;
            end
          end
          PAD_LEN: push_byte = len_byte;
          default: push = 1'b0;
        endcase
        if (push && fill_r == FILL_LAST) state_nxt = ST_COMP;
      end
      ST_COMP: begin
        if (core_done) begin
          priority if (pad_r == PAD_LEN) begin
            state_nxt = ST_DONE;
          end else if (pad_r == PAD_NONE) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_DONE: begin
        if (!out_busy) begin
          out_load   = 1'b1;
          core_clear = 1'b1;
          bits_nxt   = '0;
          pad_nxt    = PAD_NONE;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    fill_nxt = push ? fill_r + 6'd1 : fill_r;
  end

  assign core_start = push && (fill_r == FILL_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pad_r   <= PAD_NONE;
      fill_r  <= '0;
      bits_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pad_r   <= pad_nxt;
      fill_r  <= fill_nxt;
      bits_r  <= bits_nxt;
    end
  end

  always_comb begin
    sched_ctl.push      = push;
    sched_ctl.word_done = (fill_r[1:0] == 2'b11);
    sched_ctl.data      = push_byte;
    sched_ctl.step      = core_step;
    sched_ctl.calc      = core_calc;
  end

  sha_sched u_sched (
    .clk (clk),
    .ctl (sched_ctl),
    .w   (sched_w)
  );

  sha_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (core_start),
    .clear (core_clear),
    .w     (sched_w),
    .busy  (core_busy),
    .done  (core_done),
    .step  (core_step),
    .calc  (core_calc),
    .chain (chain)
  );

  sha_out u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (out_load),
    .digest (chain),
    .busy   (out_busy),
    .out_ch (out_ch)
  );

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    core_start |-> !core_busy)
    else $error("block started during compression");

  a_start_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    core_start |=> fill_r == 6'd0 && state_r == ST_COMP)
    else $error("fill count did not wrap at block start");

endmodule

`default_nettype wire
